// File: rtl/core/mwia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwia_pkg
// Shared types, op codes and width helpers for the multi-width integer ALU.
// ----------------------------------------------------------------------------
package mwia_pkg;

    localparam int DATA_W     = 64;
    localparam int DIV_STAGES = DATA_W;
    localparam int SH_W       = 6;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_AND = 4'd5,
        OP_OR  = 4'd6,
        OP_XOR = 4'd7,
        OP_SHL = 4'd8,
        OP_SHR = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        W_8  = 2'd0,
        W_16 = 2'd1,
        W_32 = 2'd2,
        W_64 = 2'd3
    } t_wsel;

    // side data carried alongside the divider
    typedef struct packed {
        logic [3:0]        op;
        logic [1:0]        wsel;
        logic              neg_q;
        logic              neg_r;
        logic              div0;
        logic [DATA_W-1:0] res;
    } t_side;

    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] wsel);
        logic [DATA_W-1:0] m;
        unique case (wsel)
            W_8:     m = 64'h0000_0000_0000_00FF;
            W_16:    m = 64'h0000_0000_0000_FFFF;
            W_32:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] sext_w(input logic [DATA_W-1:0] v,
                                                 input logic [1:0]        wsel);
        logic [DATA_W-1:0] s;
        unique case (wsel)
            W_8:     s = {{56{v[7]}}, v[7:0]};
            W_16:    s = {{48{v[15]}}, v[15:0]};
            W_32:    s = {{32{v[31]}}, v[31:0]};
            default: s = v;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/mwia_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwia_front
// Input register, operand masking, simple ops, split multiply and divider
// operand preparation (four stages).
// ----------------------------------------------------------------------------
module mwia_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [3:0]                i_op,
    input  wire logic [1:0]                i_wsel,
    input  wire logic                      i_uns,
    input  wire logic [mwia_pkg::DATA_W-1:0] i_lhs,
    input  wire logic [mwia_pkg::DATA_W-1:0] i_rhs,
    output logic                           o_valid,
    output mwia_pkg::t_side                o_side,
    output logic [mwia_pkg::DATA_W-1:0]    o_dvd,
    output logic [mwia_pkg::DATA_W-1:0]    o_dvs
);
    import mwia_pkg::*;

    // stage A
    logic              r_a_valid;
    logic [3:0]        r_a_op;
    logic [1:0]        r_a_wsel;
    logic              r_a_uns;
    logic [DATA_W-1:0] r_a_lhs, r_a_rhs;
    // stage B
    logic              r_b_valid;
    logic [3:0]        r_b_op;
    logic [1:0]        r_b_wsel;
    logic              r_b_uns;
    logic [DATA_W-1:0] r_b_a, r_b_b, r_b_as, r_b_bs;
    logic [SH_W-1:0]   r_b_sh;
    // stage C
    logic              r_c_valid;
    logic [3:0]        r_c_op;
    logic [1:0]        r_c_wsel;
    logic              r_c_neg_q, r_c_neg_r, r_c_div0;
    logic [DATA_W-1:0] r_c_res, r_c_lo, r_c_dvd, r_c_dvs;
    logic [31:0]       r_c_m1, r_c_m2;
    // stage D
    logic              r_d_valid;
    t_side             r_d_side;
    logic [DATA_W-1:0] r_d_dvd, r_d_dvs;

    logic [DATA_W-1:0] n_b_mask, n_b_a, n_b_b;
    logic [SH_W-1:0]   n_b_sh;
    logic [DATA_W-1:0] n_c_res, n_c_lo, n_c_dvd, n_c_dvs;
    logic [31:0]       n_c_p1, n_c_p2;
    logic [31:0]       n_d_mid;

    always_comb begin
        n_b_mask = width_mask(r_a_wsel);
        n_b_a    = r_a_lhs & n_b_mask;
        n_b_b    = r_a_rhs & n_b_mask;
        unique case (r_a_wsel)
            W_8:     n_b_sh = {3'b000, n_b_b[2:0]};
            W_16:    n_b_sh = {2'b00, n_b_b[3:0]};
            W_32:    n_b_sh = {1'b0, n_b_b[4:0]};
            default: n_b_sh = n_b_b[5:0];
        endcase
    end

    always_comb begin
        unique case (r_b_op)
            OP_ADD:  n_c_res = r_b_a + r_b_b;
            OP_SUB:  n_c_res = r_b_a - r_b_b;
            OP_AND:  n_c_res = r_b_a & r_b_b;
            OP_OR:   n_c_res = r_b_a | r_b_b;
            OP_XOR:  n_c_res = r_b_a ^ r_b_b;
            OP_SHL:  n_c_res = r_b_a << r_b_sh;
            OP_SHR:  n_c_res = r_b_uns ? (r_b_a >> r_b_sh)
                                       : DATA_W'($signed(r_b_as) >>> r_b_sh);
            default: n_c_res = '0;
        endcase
        n_c_lo  = r_b_a[31:0] * r_b_b[31:0];
        n_c_p1  = r_b_a[31:0] * r_b_b[63:32];
        n_c_p2  = r_b_a[63:32] * r_b_b[31:0];
        n_c_dvd = r_b_uns ? r_b_a : (r_b_as[63] ? (64'd0 - r_b_as) : r_b_as);
        n_c_dvs = r_b_uns ? r_b_b : (r_b_bs[63] ? (64'd0 - r_b_bs) : r_b_bs);
        n_d_mid = r_c_m1 + r_c_m2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_op    <= i_op;
            r_a_wsel  <= i_wsel;
            r_a_uns   <= i_uns;
            r_a_lhs   <= i_lhs;
            r_a_rhs   <= i_rhs;

            r_b_op    <= r_a_op;
            r_b_wsel  <= r_a_wsel;
            r_b_uns   <= r_a_uns;
            r_b_a     <= n_b_a;
            r_b_b     <= n_b_b;
            r_b_as    <= sext_w(n_b_a, r_a_wsel);
            r_b_bs    <= sext_w(n_b_b, r_a_wsel);
            r_b_sh    <= n_b_sh;

            r_c_op    <= r_b_op;
            r_c_wsel  <= r_b_wsel;
            r_c_neg_q <= !r_b_uns && (r_b_as[63] ^ r_b_bs[63]);
            r_c_neg_r <= !r_b_uns && r_b_as[63];
            r_c_div0  <= (r_b_b == '0);
            r_c_res   <= n_c_res;
            r_c_lo    <= n_c_lo;
            r_c_m1    <= n_c_p1;
            r_c_m2    <= n_c_p2;
            r_c_dvd   <= n_c_dvd;
            r_c_dvs   <= n_c_dvs;

            r_d_side.op    <= r_c_op;
            r_d_side.wsel  <= r_c_wsel;
            r_d_side.neg_q <= r_c_neg_q;
            r_d_side.neg_r <= r_c_neg_r;
            r_d_side.div0  <= r_c_div0;
            r_d_side.res   <= (r_c_op == OP_MUL) ? (r_c_lo + {n_d_mid, 32'd0}) : r_c_res;
            r_d_dvd        <= r_c_dvd;
            r_d_dvs        <= r_c_dvs;
        end
    end

    assign o_valid = r_d_valid;
    assign o_side  = r_d_side;
    assign o_dvd   = r_d_dvd;
    assign o_dvs   = r_d_dvs;

endmodule
`default_nettype wire

// File: rtl/core/mwia_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwia_div
// Pipelined restoring divider, one quotient bit per stage, side data in step.
// ----------------------------------------------------------------------------
module mwia_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire mwia_pkg::t_side             i_side,
    input  wire logic [mwia_pkg::DATA_W-1:0] i_dvd,
    input  wire logic [mwia_pkg::DATA_W-1:0] i_dvs,
    output logic                             o_valid,
    output mwia_pkg::t_side                  o_side,
    output logic [mwia_pkg::DATA_W-1:0]      o_quo,
    output logic [mwia_pkg::DATA_W-1:0]      o_rem
);
    import mwia_pkg::*;

    logic [DIV_STAGES-1:0] r_vld;
    logic [DATA_W-1:0]     r_rem [DIV_STAGES];
    logic [DATA_W-1:0]     r_quo [DIV_STAGES];
    logic [DATA_W-1:0]     r_dvs [DIV_STAGES];
    t_side                 r_side [DIV_STAGES];

    logic [DATA_W-1:0]     n_rem [DIV_STAGES];
    logic [DATA_W-1:0]     n_quo [DIV_STAGES];
    logic [DATA_W-1:0]     rem_in [DIV_STAGES];
    logic [DATA_W-1:0]     quo_in [DIV_STAGES];
    logic [DATA_W-1:0]     dvs_in [DIV_STAGES];
    logic [DATA_W:0]       trial [DIV_STAGES];

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            rem_in[k] = (k == 0) ? '0    : r_rem[(k == 0) ? 0 : k - 1];
            quo_in[k] = (k == 0) ? i_dvd : r_quo[(k == 0) ? 0 : k - 1];
            dvs_in[k] = (k == 0) ? i_dvs : r_dvs[(k == 0) ? 0 : k - 1];
            trial[k]  = {rem_in[k], quo_in[k][DATA_W-1]};
            if (trial[k] >= {1'b0, dvs_in[k]}) begin
                n_rem[k] = DATA_W'(trial[k] - {1'b0, dvs_in[k]});
                n_quo[k] = {quo_in[k][DATA_W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[k][DATA_W-1:0];
                n_quo[k] = {quo_in[k][DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_quo[k]  <= n_quo[k];
                r_dvs[k]  <= dvs_in[k];
                r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];
    assign o_rem   = r_rem[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/core/mwia_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwia_back
// Quotient/remainder sign fix, result select, width mask and output register.
// ----------------------------------------------------------------------------
module mwia_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire mwia_pkg::t_side             i_side,
    input  wire logic [mwia_pkg::DATA_W-1:0] i_quo,
    input  wire logic [mwia_pkg::DATA_W-1:0] i_rem,
    output logic                             o_valid,
    output logic [mwia_pkg::DATA_W-1:0]      o_zext,
    output logic [mwia_pkg::DATA_W-1:0]      o_sext,
    output logic                             o_zero,
    output logic                             o_handled
);
    import mwia_pkg::*;

    logic              r_e_valid, r_e_handled;
    logic [1:0]        r_e_wsel;
    logic [DATA_W-1:0] r_e_res;
    logic              r_f_valid, r_f_handled, r_f_zero;
    logic [DATA_W-1:0] r_f_zext, r_f_sext;

    logic [DATA_W-1:0] n_e_res, n_f_m;
    logic              n_e_handled, n_e_is_div;

    always_comb begin
        n_e_is_div = (i_side.op == OP_DIV) || (i_side.op == OP_MOD);
        unique case (i_side.op)
            OP_DIV:  n_e_res = i_side.neg_q ? (64'd0 - i_quo) : i_quo;
            OP_MOD:  n_e_res = i_side.neg_r ? (64'd0 - i_rem) : i_rem;
            default: n_e_res = i_side.res;
        endcase
        n_e_handled = (i_side.op <= OP_SHR) && !(n_e_is_div && i_side.div0);
        n_f_m       = r_e_res & width_mask(r_e_wsel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= i_valid;
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_res     <= n_e_res;
            r_e_wsel    <= i_side.wsel;
            r_e_handled <= n_e_handled;
            r_f_handled <= r_e_handled;
            r_f_zext    <= r_e_handled ? n_f_m : '0;
            r_f_sext    <= r_e_handled ? sext_w(n_f_m, r_e_wsel) : '0;
            r_f_zero    <= r_e_handled && (n_f_m == '0);
        end
    end

    assign o_valid   = r_f_valid;
    assign o_zext    = r_f_zext;
    assign o_sext    = r_f_sext;
    assign o_zero    = r_f_zero;
    assign o_handled = r_f_handled;

endmodule
`default_nettype wire

// File: rtl/core/multi_width_integer_alu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_width_integer_alu_core
// Add/sub/mul/div/mod/logic/shift at 8, 16, 32 or 64 bits, signed or unsigned.
// ----------------------------------------------------------------------------
// Stages from input transfer to result on the output port: 4 front stages,
//   64 divider stages, 2 back stages; the 64-stage divider sets the depth.
// Throughput: one item per cycle while the output is not stalled.
// A stall on the output freezes the whole pipeline; nothing is lost.
// Reset (synchronous, active low) clears all valid bits; no clearing pass.
module multi_width_integer_alu_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op[3:0], width_sel[5:4], unsigned_mode[6], lhs_value[70:7],
    // rhs_value[134:71], zero pad[135]
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_zext[63:0], result_sext[127:64], result_zero[128], handled[129],
    // zero pad[135:130]
    output logic [135:0]      m_axis_tdata
);
    import mwia_pkg::*;

    logic              en;
    logic              f_valid, d_valid;
    t_side             f_side, d_side;
    logic [DATA_W-1:0] f_dvd, f_dvs, d_quo, d_rem;
    logic [DATA_W-1:0] res_zext, res_sext;
    logic              res_zero, res_handled;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    mwia_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tdata[3:0]),
        .i_wsel  (s_axis_tdata[5:4]),
        .i_uns   (s_axis_tdata[6]),
        .i_lhs   (s_axis_tdata[70:7]),
        .i_rhs   (s_axis_tdata[134:71]),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_dvd   (f_dvd),
        .o_dvs   (f_dvs)
    );

    mwia_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_dvd   (f_dvd),
        .i_dvs   (f_dvs),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_quo   (d_quo),
        .o_rem   (d_rem)
    );

    mwia_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (d_valid),
        .i_side    (d_side),
        .i_quo     (d_quo),
        .i_rem     (d_rem),
        .o_valid   (m_axis_tvalid),
        .o_zext    (res_zext),
        .o_sext    (res_sext),
        .o_zero    (res_zero),
        .o_handled (res_handled)
    );

    assign m_axis_tdata = {6'd0, res_handled, res_zero, res_sext, res_zext};

    a_unhandled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res_handled |-> res_zext == '0 && res_sext == '0 && !res_zero)
        else $error("unhandled result not cleared");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res_handled |-> res_zero == (res_zext == '0))
        else $error("zero flag mismatch");

    a_sext_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res_sext[7:0] == res_zext[7:0])
        else $error("sign-extended result disagrees with masked result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(res_zext) && $stable(res_handled))
        else $error("output changed during stall");

endmodule
`default_nettype wire
